/* rtl/core/tdws_pkg.sv */
// ----------------------------------------------------------------------------
// Two-wire display serializer package
// Shared types and constants for the serializer core.
// ----------------------------------------------------------------------------
package tdws_pkg;

	localparam int DEF_FIFO_DEPTH      = 16;
	localparam int DEF_MAX_FRAME_BYTES = 16;
	localparam int HALVES_PER_BYTE     = 18;
	localparam int NAK_BITS            = 16;

	typedef enum logic [3:0] {
		PH_IDLE         = 4'd0,
		PH_BITS         = 4'd1,
		PH_GAP          = 4'd2,
		PH_STOP_END_HI  = 4'd3,
		PH_STOP_END_REL = 4'd4,
		PH_STOP_RE_HI   = 4'd5,
		PH_STOP_RE_REL  = 4'd6,
		PH_RESTART      = 4'd7,
		PH_STOP_END_LO  = 4'd8
	} phase_t;

	typedef struct packed {
		logic       last;
		logic       cmd;
		logic [7:0] data_byte;
	} fifo_entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

endpackage

/* rtl/core/tdws_fifo.sv */
// ----------------------------------------------------------------------------
// Byte FIFO
// Queues bytes with their flags; the head entry is kept in a register that
// is refreshed from the memory every cycle, with write bypass.
// ----------------------------------------------------------------------------
module tdws_fifo #(
	parameter int FIFO_DEPTH = tdws_pkg::DEF_FIFO_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  tdws_pkg::fifo_entry_t wdata,
	input  logic                 pop,
	output tdws_pkg::fifo_entry_t head,
	output tdws_pkg::fifo_stat_t  stat
);
	import tdws_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	fifo_entry_t       mem [FIFO_DEPTH];
	fifo_entry_t       head_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic [PTR_W-1:0]  rd_ptr_n;
	logic              wr_en;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign stat.full  = (count_q == CNT_W'(FIFO_DEPTH));
	assign stat.empty = (count_q == '0);
	assign wr_en      = push && !stat.full;
	assign rd_ptr_n   = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
	assign head       = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			rd_ptr_q <= rd_ptr_n;
			if (wr_en) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
				count_q  <= count_q + CNT_W'(1);
			end else if (pop) begin
				count_q  <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wdata;
		end
		if (wr_en && (wr_ptr_q == rd_ptr_n)) begin
			head_q <= wdata;
		end else begin
			head_q <= mem[rd_ptr_n];
		end
	end

endmodule

/* rtl/core/tdws_link.sv */
// ----------------------------------------------------------------------------
// Link sequencer
// Half-period state machine for START, data bits, ack and STOP framing.
// ----------------------------------------------------------------------------
module tdws_link #(
	parameter int MAX_FRAME_BYTES = tdws_pkg::DEF_MAX_FRAME_BYTES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  tick,
	input  logic                  sample,
	input  tdws_pkg::fifo_entry_t head,
	input  tdws_pkg::fifo_stat_t  fstat,
	output logic                  pop,
	output logic                  clk_n,
	output logic                  dio_n,
	output logic                  busy_n,
	output logic                  done,
	output logic [15:0]           nak_n
);
	import tdws_pkg::*;

	localparam int IDX_W = $clog2(MAX_FRAME_BYTES + 1);

	phase_t            phase_q, phase_n;
	logic [4:0]        cnt_q, cnt_n;
	logic [7:0]        shift_q, shift_n;
	logic [IDX_W-1:0]  idx_q, idx_n;
	logic [15:0]       nak_q;
	logic              last_q, last_n;
	logic              clk_q, dio_q;
	logic              gap_last;

	assign gap_last = head.last ||
		({1'b0, idx_q} >= (IDX_W + 1)'(MAX_FRAME_BYTES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			shift_q <= '0;
			idx_q   <= '0;
			nak_q   <= '0;
			last_q  <= 1'b0;
			clk_q   <= 1'b1;
			dio_q   <= 1'b1;
		end else begin
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			shift_q <= shift_n;
			idx_q   <= idx_n;
			nak_q   <= nak_n;
			last_q  <= last_n;
			clk_q   <= clk_n;
			dio_q   <= dio_n;
		end
	end

	always_comb begin
		phase_n = phase_q;
		cnt_n   = cnt_q;
		shift_n = shift_q;
		idx_n   = idx_q;
		nak_n   = nak_q;
		last_n  = last_q;
		clk_n   = clk_q;
		dio_n   = dio_q;
		pop     = 1'b0;
		done    = 1'b0;
		if (tick) begin
			unique case (phase_q)
				PH_IDLE: begin
					clk_n = 1'b1;
					dio_n = 1'b1;
					if (!fstat.empty) begin
						pop     = 1'b1;
						nak_n   = '0;
						idx_n   = '0;
						shift_n = head.data_byte;
						last_n  = head.last || (MAX_FRAME_BYTES <= 1);
						dio_n   = 1'b0;
						cnt_n   = '0;
						phase_n = PH_BITS;
					end
				end
				PH_BITS: begin
					clk_n = cnt_q[0];
					dio_n = (cnt_q < 5'd16) ? shift_q[cnt_q[3:1]] : 1'b1;
					if (cnt_q == 5'(HALVES_PER_BYTE - 1)) begin
						if (sample && (8'(idx_q) < 8'(NAK_BITS))) begin
							nak_n = nak_q | (16'd1 << idx_q);
						end
						idx_n   = idx_q + IDX_W'(1);
						cnt_n   = '0;
						phase_n = last_q ? PH_STOP_END_LO : PH_GAP;
					end else begin
						cnt_n = cnt_q + 5'd1;
					end
				end
				PH_GAP: begin
					clk_n = 1'b0;
					dio_n = 1'b1;
					if (!fstat.empty) begin
						pop     = 1'b1;
						shift_n = head.data_byte;
						last_n  = gap_last;
						if (head.cmd) begin
							dio_n   = 1'b0;
							cnt_n   = '0;
							phase_n = PH_STOP_RE_HI;
						end else begin
							// first bit half goes out right away
							dio_n   = head.data_byte[0];
							cnt_n   = 5'd1;
							phase_n = PH_BITS;
						end
					end
				end
				PH_STOP_RE_HI: begin
					clk_n   = 1'b1;
					dio_n   = 1'b0;
					phase_n = PH_STOP_RE_REL;
				end
				PH_STOP_RE_REL: begin
					clk_n   = 1'b1;
					dio_n   = 1'b1;
					phase_n = PH_RESTART;
				end
				PH_RESTART: begin
					clk_n   = 1'b1;
					dio_n   = 1'b0;
					cnt_n   = '0;
					phase_n = PH_BITS;
				end
				PH_STOP_END_LO: begin
					clk_n   = 1'b0;
					dio_n   = 1'b0;
					phase_n = PH_STOP_END_HI;
				end
				PH_STOP_END_HI: begin
					clk_n   = 1'b1;
					dio_n   = 1'b0;
					phase_n = PH_STOP_END_REL;
				end
				PH_STOP_END_REL: begin
					clk_n   = 1'b1;
					dio_n   = 1'b1;
					last_n  = 1'b0;
					done    = 1'b1;
					phase_n = PH_IDLE;
				end
				default: begin
					clk_n   = 1'b1;
					dio_n   = 1'b1;
					phase_n = PH_IDLE;
				end
			endcase
		end
		busy_n = (phase_n != PH_IDLE);
	end

endmodule

/* rtl/core/two_wire_display_serializer.sv */
// ----------------------------------------------------------------------------
// Two-wire display serializer
// Write-only two-wire link master: queued bytes go out with START/STOP
// framing, one half clock period per tick word, with ack sampling.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle unless m_tready stalls the result register;
// each tick word is one pass through the link state machine and each push
// word one FIFO write attempt, between the input register and the result register.
// Reset: asynchronous; lines high, link idle, FIFO empty, NAK mask zero.
// FIFO storage itself is not cleared.
module two_wire_display_serializer #(
	parameter int FIFO_DEPTH      = tdws_pkg::DEF_FIFO_DEPTH,
	parameter int MAX_FRAME_BYTES = tdws_pkg::DEF_MAX_FRAME_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // byte_value[7:0], dio_sample[8], zero pad
	input  logic [1:0]  s_tuser,  // operation[0], starts_command[1]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // clk_out[0], dio_out[1], busy_res[2],
	                              // nak_mask[18:3], zero pad
	output logic        m_tuser,  // push_rejected[0]
	output logic        m_tlast
);
	import tdws_pkg::*;

	logic        valid_s1;
	logic        op_s1;
	logic [7:0]  byte_s1;
	logic        cmd_s1;
	logic        last_s1;
	logic        dio_s1;
	logic        advance;

	logic        m_valid_q;
	logic        clk_out_q;
	logic        dio_out_q;
	logic        busy_q;
	logic        done_q;
	logic [15:0] nak_q;
	logic        rej_q;

	fifo_entry_t wdata;
	fifo_entry_t head;
	fifo_stat_t  fstat;
	logic        push;
	logic        tick;
	logic        pop;
	logic        clk_n;
	logic        dio_n;
	logic        busy_n;
	logic        done;
	logic [15:0] nak_n;

	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign push     = advance && !op_s1;
	assign tick     = advance && op_s1;

	assign wdata.last      = last_s1;
	assign wdata.cmd       = cmd_s1;
	assign wdata.data_byte = byte_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= s_tuser[0];
			cmd_s1  <= s_tuser[1];
			byte_s1 <= s_tdata[7:0];
			dio_s1  <= s_tdata[8];
			last_s1 <= s_tlast;
		end
	end

	tdws_fifo #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wdata),
		.pop    (pop),
		.head   (head),
		.stat   (fstat)
	);

	tdws_link #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_link (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.sample (dio_s1),
		.head   (head),
		.fstat  (fstat),
		.pop    (pop),
		.clk_n  (clk_n),
		.dio_n  (dio_n),
		.busy_n (busy_n),
		.done   (done),
		.nak_n  (nak_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			clk_out_q <= clk_n;
			dio_out_q <= dio_n;
			busy_q    <= busy_n;
			done_q    <= done;
			nak_q     <= nak_n;
			rej_q     <= push && fstat.full;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {5'd0, nak_q, busy_q, dio_out_q, clk_out_q};
	assign m_tuser  = rej_q;
	assign m_tlast  = done_q;

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (tick && !fstat.empty))
		else $error("pop from empty FIFO");

	a_done_lines: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && done_q) |-> (clk_out_q && dio_out_q && !busy_q))
		else $error("frame end without released lines");

	a_rej_push: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && rej_q) |-> !done_q)
		else $error("rejected push marked as frame end");

	a_push_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!pop && !done))
		else $error("push word moved the link");

endmodule

/* sim/tb_two_wire_display_serializer.sv */
// ----------------------------------------------------------------------------
// Two-wire display serializer testbench
// Drives push and tick words into the serializer and checks every result
// word against a cycle-free model of the link: FIFO, START/STOP framing,
// bit halves, ack sampling into the NAK mask and frame completion.
// Directed frames cover the corner cases; random frames with random pacing
// and output stalls cover the rest.
// ----------------------------------------------------------------------------
module tb_two_wire_display_serializer;
	import tdws_pkg::*;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_TICK = 1'b1;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_WORDS = 1950;

	typedef struct {
		logic        clk_o;
		logic        dio_o;
		logic        busy;
		logic        done;
		logic [15:0] nak;
		logic        rejected;
	} link_levels_t;

	class link_scoreboard;
		fifo_entry_t  fifo_mem [DEF_FIFO_DEPTH];
		int unsigned  rd_ptr;
		int unsigned  count;
		int unsigned  half_idx;
		int unsigned  byte_idx;
		phase_t       phase;
		logic [7:0]   shreg;
		logic [15:0]  nak;
		logic         in_last;
		logic         clk_lvl;
		logic         dio_lvl;
		link_levels_t expected_q[$];
		int           errors;

		function new();
			rd_ptr   = 0;
			count    = 0;
			half_idx = 0;
			byte_idx = 0;
			phase    = PH_IDLE;
			shreg    = '0;
			nak      = '0;
			in_last  = 1'b0;
			clk_lvl  = 1'b1;
			dio_lvl  = 1'b1;
			errors   = 0;
		endfunction

		function fifo_entry_t pop_entry();
			fifo_entry_t e;
			e = fifo_mem[rd_ptr];
			rd_ptr = (rd_ptr + 1) % DEF_FIFO_DEPTH;
			count--;
			return e;
		endfunction

		function void load_entry(fifo_entry_t e);
			shreg   = e.data_byte;
			in_last = e.last || (byte_idx + 1 >= DEF_MAX_FRAME_BYTES);
		endfunction

		function void clock_half(logic ack);
			clk_lvl = half_idx[0];
			dio_lvl = (half_idx < 16) ? shreg[half_idx >> 1] : 1'b1;
			if (half_idx + 1 >= HALVES_PER_BYTE) begin
				if (ack && byte_idx < NAK_BITS)
					nak[byte_idx] = 1'b1;
				if (byte_idx < 64)
					byte_idx++;
				half_idx = 0;
				phase = in_last ? PH_STOP_END_LO : PH_GAP;
			end else begin
				half_idx++;
			end
		endfunction

		// one half clock period; returns 1 when the final STOP completes
		function logic advance_line(logic ack);
			fifo_entry_t e;
			case (phase)
				PH_IDLE: begin
					if (count == 0) begin
						clk_lvl = 1'b1;
						dio_lvl = 1'b1;
						return 1'b0;
					end
					nak = '0;
					byte_idx = 0;
					load_entry(pop_entry());
					clk_lvl = 1'b1;
					dio_lvl = 1'b0;
					half_idx = 0;
					phase = PH_BITS;
				end
				PH_BITS: clock_half(ack);
				PH_GAP: begin
					if (count == 0) begin
						clk_lvl = 1'b0;
						dio_lvl = 1'b1;
						return 1'b0;
					end
					e = pop_entry();
					load_entry(e);
					half_idx = 0;
					if (e.cmd) begin
						clk_lvl = 1'b0;
						dio_lvl = 1'b0;
						phase = PH_STOP_RE_HI;
					end else begin
						phase = PH_BITS;
						clock_half(ack);
					end
				end
				PH_STOP_RE_HI: begin
					clk_lvl = 1'b1;
					dio_lvl = 1'b0;
					phase = PH_STOP_RE_REL;
				end
				PH_STOP_RE_REL: begin
					clk_lvl = 1'b1;
					dio_lvl = 1'b1;
					phase = PH_RESTART;
				end
				PH_RESTART: begin
					clk_lvl = 1'b1;
					dio_lvl = 1'b0;
					half_idx = 0;
					phase = PH_BITS;
				end
				PH_STOP_END_LO: begin
					clk_lvl = 1'b0;
					dio_lvl = 1'b0;
					phase = PH_STOP_END_HI;
				end
				PH_STOP_END_HI: begin
					clk_lvl = 1'b1;
					dio_lvl = 1'b0;
					phase = PH_STOP_END_REL;
				end
				PH_STOP_END_REL: begin
					clk_lvl = 1'b1;
					dio_lvl = 1'b1;
					phase = PH_IDLE;
					in_last = 1'b0;
					return 1'b1;
				end
				default: begin
					phase = PH_IDLE;
					clk_lvl = 1'b1;
					dio_lvl = 1'b1;
				end
			endcase
			return 1'b0;
		endfunction

		function void note_input(logic op, logic [7:0] b, logic cmd, logic last, logic ack);
			link_levels_t r;
			r.done = 1'b0;
			r.rejected = 1'b0;
			if (op == OP_PUSH) begin
				if (count >= DEF_FIFO_DEPTH) begin
					r.rejected = 1'b1;
				end else begin
					fifo_mem[(rd_ptr + count) % DEF_FIFO_DEPTH] =
						'{last: last, cmd: cmd, data_byte: b};
					count++;
				end
			end else begin
				r.done = advance_line(ack);
			end
			r.clk_o = clk_lvl;
			r.dio_o = dio_lvl;
			r.busy  = (phase != PH_IDLE);
			r.nak   = nak;
			expected_q.push_back(r);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void compare(string name, logic [15:0] exp, logic [15:0] act);
			if (act !== exp) begin
				$display("%0t: %s mismatch, expected %h actual %h", $time, name, exp, act);
				errors++;
			end
		endfunction

		function void check_result(logic [23:0] word, logic rej, logic done);
			link_levels_t r;
			if (expected_q.size() == 0) begin
				$display("%0t: result word %h with nothing expected, expected none actual %h",
					$time, word, word);
				errors++;
				return;
			end
			r = expected_q.pop_front();
			compare("clk_out", r.clk_o, word[0]);
			compare("dio_out", r.dio_o, word[1]);
			compare("busy_res", r.busy, word[2]);
			compare("nak_mask", r.nak, word[18:3]);
			compare("tdata pad", 16'd0, {11'd0, word[23:19]});
			compare("push_rejected", r.rejected, rej);
			compare("frame_done", r.done, done);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b1;
	logic [23:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	link_scoreboard sb = new();
	int             words_sent = 0;
	int             burst_left = 0;
	int             idle_cycles = 0;
	logic [5:0]     stall_cnt = '0;
	logic [1:0]     stall_mode = '0;

	two_wire_display_serializer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// output stalls: a new mode is drawn whenever stall_cnt reaches 63
	always @(posedge clk) begin
		stall_cnt <= stall_cnt + 1'b1;
		if (stall_cnt == 6'd63)
			stall_mode <= 2'($urandom_range(0, 3));
		case (stall_mode)
			2'd0: m_tready <= 1'b1;
			2'd1: m_tready <= (stall_cnt[1:0] != 2'd3);
			2'd2: m_tready <= 1'($urandom_range(0, 1));
			default: m_tready <= (stall_cnt[3:2] != 2'd0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser, m_tlast);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("two_wire_display_serializer regression: fail");
				$finish;
			end
		end
	end

	task automatic send_word(logic op, logic [7:0] b, logic cmd, logic last, logic ack);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, ack, b};
		s_tuser  <= {cmd, op};
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_input(op, b, cmd, last, ack);
		words_sent++;
	endtask

	task automatic push_byte(logic [7:0] b, logic cmd, logic last);
		send_word(OP_PUSH, b, cmd, last, 1'($urandom_range(0, 1)));
	endtask

	task automatic tick_line(int n);
		repeat (n)
			send_word(OP_TICK, 8'($urandom), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	// tick until the link is idle or holds in a gap with an empty FIFO
	task automatic drain_link();
		while (!(sb.count == 0 && (sb.phase == PH_IDLE || sb.phase == PH_GAP)))
			tick_line(1);
	endtask

	task automatic wait_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	initial begin
		int len;
		int i;
		int r;
		int next_pause;
		logic broken;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle ticks, command flag on first byte, STOP/START between commands
		tick_line(2);
		push_byte(8'h00, 1'b1, 1'b0);
		push_byte(8'hFF, 1'b1, 1'b0);
		push_byte(8'h5A, 1'b0, 1'b1);
		drain_link();

		// FIFO runs dry mid-frame: clock held low, then plain and command bytes
		push_byte(8'h81, 1'b0, 1'b0);
		drain_link();
		tick_line(4);
		push_byte(8'h3C, 1'b0, 1'b0);
		drain_link();
		tick_line(3);
		push_byte(8'hC3, 1'b1, 1'b1);
		drain_link();

		// fill the FIFO, one push rejected; the frame is cut at its maximum length
		for (i = 0; i < DEF_FIFO_DEPTH + 1; i++)
			push_byte(8'(i * 37 + 5), (i % 3) == 1, 1'b0);
		drain_link();
		wait_results();

		next_pause = 600;
		while (words_sent < RANDOM_WORDS) begin
			r = $urandom_range(0, 19);
			if (r < 14)
				len = $urandom_range(1, 4);
			else if (r < 19)
				len = $urandom_range(5, 12);
			else
				len = $urandom_range(13, 20);
			broken = ($urandom_range(0, 9) == 0);
			tick_line($urandom_range(0, 3));
			i = 0;
			while (i < len) begin
				if ($urandom_range(0, 99) < 35 &&
					(sb.count < DEF_FIFO_DEPTH || $urandom_range(0, 19) == 0)) begin
					push_byte(8'($urandom), $urandom_range(0, 9) < 3,
						(i == len - 1) && !broken);
					i++;
				end else begin
					tick_line(1);
				end
			end
			drain_link();
			if (words_sent >= next_pause) begin
				wait_results();
				next_pause += 600;
			end
		end

		wait_results();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("two_wire_display_serializer regression: pass");
		else
			$display("two_wire_display_serializer regression: fail");
		$finish;
	end

endmodule
